@@ sv/zae_pkg.sv @@
// Shared types, fixed-point constants and register codes of the zonal aberration evaluator.
package zae_pkg;

    localparam int MAX_TERMS    = 6;
    localparam int NUM_LANES    = MAX_TERMS - 1;
    localparam int NUM_STATIONS = 2 * NUM_LANES;
    localparam int CELL_LAT     = 4;
    localparam int FRONT_LAT    = 2;
    localparam int PIPE_LAT     = FRONT_LAT + NUM_STATIONS * CELL_LAT;

    localparam int WORD_W      = 48;
    localparam int COEF_W      = 32;
    localparam int COEF_ALIGN  = 12;
    localparam int COORD_W     = 18;
    localparam int RAD_W       = 36;
    localparam int OPB_W       = RAD_W + 1;
    localparam int COUNT_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int RAD_SHIFT   = 32;
    localparam int COEF_SHIFT  = 20;

    typedef logic signed [WORD_W-1:0]  t_word;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic        [RAD_W-1:0]   t_rad;
    typedef logic signed [OPB_W-1:0]   t_opb;
    typedef logic        [COUNT_W-1:0] t_count;
    typedef logic        [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam t_word ONE_Q32  = 48'sd4294967296;

    localparam t_cfg_idx REG_BASIS_MODE = 3'd0;
    localparam t_cfg_idx REG_TERM_COUNT = 3'd1;
    localparam t_cfg_idx REG_COEFF_0    = 3'd2;
    localparam t_cfg_idx REG_COEFF_5    = 3'd7;

    localparam logic BASIS_POWER  = 1'b0;
    localparam logic BASIS_RADIAL = 1'b1;

    // radial polynomial constants in Q16.32, highest power first, leading one omitted
    localparam t_word POLY_CONST [15] = '{
        -48'sd2147483648,
        -48'sd4294967296,  48'sd715827884,
        -48'sd6442450944,  48'sd2576980378, -48'sd214748365,
        -48'sd8589934592,  48'sd5522082402, -48'sd1227132286,  48'sd61332133,
        -48'sd10737418240, 48'sd9544370814, -48'sd3579139270,  48'sd511315857,
        -48'sd17042430
    };
    localparam int POLY_START [MAX_TERMS] = '{0, 0, 1, 3, 6, 10};

    function automatic t_word coef_word(input t_coef c);
        return {{(WORD_W-COEF_W-COEF_ALIGN){c[COEF_W-1]}}, c, {COEF_ALIGN{1'b0}}};
    endfunction

    function automatic t_opb coef_opb(input t_coef c);
        return {{(OPB_W-COEF_W){c[COEF_W-1]}}, c};
    endfunction

endpackage

@@ sv/zae_delay.sv @@
// Enabled shift line that carries a word alongside the multiply-add cells.
module zae_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_adv,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tap[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

@@ sv/zae_cell.sv @@
// Four-stage saturating multiply-add cell: y = clip(clip(floor(a * b / 2^SHIFT)) + d), or y = pass when inactive.
module zae_cell #(
    parameter int SHIFT = 32
) (
    input  logic           i_clk,
    input  logic           i_adv,
    input  logic           i_act,
    input  zae_pkg::t_word i_a,
    input  zae_pkg::t_opb  i_b,
    input  zae_pkg::t_word i_d,
    input  zae_pkg::t_word i_pass,
    output zae_pkg::t_word o_y,
    output logic           o_sat
);
    import zae_pkg::*;

    localparam int MA_W   = WORD_W;
    localparam int MB_W   = OPB_W - 1;
    localparam int HALF_W = MA_W / 2;
    localparam int PP_W   = HALF_W + MB_W;
    localparam int PROD_W = MA_W + MB_W;
    localparam int Q_W    = PROD_W - SHIFT + 1;
    localparam logic [Q_W-1:0] LIM_POS = Q_W'(WORD_MAX);
    localparam logic [Q_W-1:0] LIM_NEG = LIM_POS + 1'b1;

    logic [MA_W-1:0]   w_ma;
    logic [MB_W-1:0]   w_mb;
    logic [PP_W-1:0]   w_pl;
    logic [PP_W-1:0]   w_ph;
    logic [PROD_W-1:0] w_prod;
    logic [Q_W-1:0]    w_q;
    logic              w_over;
    t_word             w_m;
    logic [WORD_W:0]   w_sum;
    logic              w_sum_ovf;
    t_word             w_clip;

    logic [PP_W-1:0]   r1_pl;
    logic [PP_W-1:0]   r1_ph;
    logic              r1_neg;
    logic              r1_act;
    t_word             r1_d;
    t_word             r1_pass;
    logic [PROD_W-1:0] r2_prod;
    logic              r2_neg;
    logic              r2_act;
    t_word             r2_d;
    t_word             r2_pass;
    t_word             r3_m;
    logic              r3_sat;
    logic              r3_act;
    t_word             r3_d;
    t_word             r3_pass;
    t_word             r4_y;
    logic              r4_sat;

    assign w_ma = i_a[WORD_W-1] ? MA_W'(-i_a) : MA_W'(i_a);
    assign w_mb = i_b[OPB_W-1]  ? MB_W'(-i_b) : MB_W'(i_b);
    assign w_pl = PP_W'(w_ma[HALF_W-1:0]) * PP_W'(w_mb);
    assign w_ph = PP_W'(w_ma[MA_W-1:HALF_W]) * PP_W'(w_mb);

    assign w_prod = {r1_ph, {HALF_W{1'b0}}} + PROD_W'(r1_pl);

    assign w_q    = {1'b0, r2_prod[PROD_W-1:SHIFT]}
                  + Q_W'(r2_neg & (|r2_prod[SHIFT-1:0]));
    assign w_over = w_q > (r2_neg ? LIM_NEG : LIM_POS);

    always_comb begin
        if (w_over) begin
            w_m = r2_neg ? WORD_MIN : WORD_MAX;
        end else if (r2_neg) begin
            w_m = -t_word'(w_q[WORD_W-1:0]);
        end else begin
            w_m = t_word'(w_q[WORD_W-1:0]);
        end
    end

    assign w_sum     = {r3_m[WORD_W-1], r3_m} + {r3_d[WORD_W-1], r3_d};
    assign w_sum_ovf = w_sum[WORD_W] != w_sum[WORD_W-1];
    assign w_clip    = w_sum_ovf ? (w_sum[WORD_W] ? WORD_MIN : WORD_MAX)
                                 : t_word'(w_sum[WORD_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_pl   <= w_pl;
            r1_ph   <= w_ph;
            r1_neg  <= i_a[WORD_W-1] ^ i_b[OPB_W-1];
            r1_act  <= i_act;
            r1_d    <= i_d;
            r1_pass <= i_pass;

            r2_prod <= w_prod;
            r2_neg  <= r1_neg;
            r2_act  <= r1_act;
            r2_d    <= r1_d;
            r2_pass <= r1_pass;

            r3_m    <= w_m;
            r3_sat  <= w_over;
            r3_act  <= r2_act;
            r3_d    <= r2_d;
            r3_pass <= r2_pass;

            r4_y    <= r3_act ? w_clip : r3_pass;
            r4_sat  <= r3_act & (r3_sat | w_sum_ovf);
        end
    end

    assign o_y   = r4_y;
    assign o_sat = r4_sat;

endmodule

@@ sv/zonal_aberration_evaluator.sv @@
// Top level of the zonal aberration evaluator: config registers, cell chain and output skid.
//
// Takes one pupil point (x, y) per clock and returns one Q16.32 wavefront value per point,
// in order, with a flag when any step clipped. Sustained rate is one point per cycle while
// the skid stage is empty, and o_in_ready is low while it is full. From an accepted input
// beat to the output: the r_xx/r_yy then r_rad registers form r = x^2 + y^2, then ten
// stations of four-stage multiply-add cells (five Horner stations that build every radial
// polynomial or the power series in parallel lanes, then five stations that fold
// coefficient times polynomial into the sum), then the output register. A skid stage
// behind the output register keeps the input open while one result waits. Registers are
// written through a plain write port and must only change while no point is in flight.
module zonal_aberration_evaluator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wen,
    input  logic [zae_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [zae_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [zae_pkg::COORD_W-1:0]   i_x_coord,
    input  logic signed [zae_pkg::COORD_W-1:0]   i_y_coord,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [zae_pkg::WORD_W-1:0]    o_wave_value,
    output logic                                 o_saturated
);
    import zae_pkg::*;

    logic                      r_basis_mode;
    t_count                    r_term_count;
    t_coef                     r_coeff [MAX_TERMS];

    t_count                    w_n;
    t_count                    w_top_idx;
    logic                      w_radial;
    logic                      w_adv;
    logic                      w_last;
    t_word                     w_start_hi;

    logic signed [2*COORD_W-1:0] w_xx;
    logic signed [2*COORD_W-1:0] w_yy;
    logic [RAD_W-2:0]          r_xx;
    logic [RAD_W-2:0]          r_yy;
    t_rad                      r_rad;
    logic [PIPE_LAT-1:0]       r_vld;

    t_rad                      w_rad  [0:NUM_LANES-1];
    t_word                     w_lane [1:NUM_STATIONS][1:NUM_LANES];
    logic                      w_csat [1:NUM_STATIONS][1:NUM_LANES];
    logic                      w_sat_d [1:NUM_STATIONS];
    logic                      w_sat  [1:NUM_STATIONS];
    t_word                     w_acc  [NUM_LANES:NUM_STATIONS];

    t_word                     w_result;
    logic                      w_result_sat;
    t_word                     r_out_value;
    logic                      r_out_sat;
    logic                      r_out_valid;
    t_word                     r_skid_value;
    logic                      r_skid_sat;
    logic                      r_skid_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basis_mode <= BASIS_POWER;
            r_term_count <= '0;
            for (int i = 0; i < MAX_TERMS; i++) begin
                r_coeff[i] <= '0;
            end
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index) inside
                REG_BASIS_MODE: begin
                    r_basis_mode <= i_cfg_data[0];
                end
                REG_TERM_COUNT: begin
                    r_term_count <= i_cfg_data[COUNT_W-1:0];
                end
                [REG_COEFF_0:REG_COEFF_5]: begin
                    r_coeff[CFG_IDX_W'(i_cfg_index - REG_COEFF_0)] <= t_coef'(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    assign w_n        = (r_term_count > t_count'(MAX_TERMS)) ? t_count'(MAX_TERMS)
                                                             : r_term_count;
    assign w_top_idx  = (w_n == '0) ? '0 : w_n - 1'b1;
    assign w_radial   = r_basis_mode == BASIS_RADIAL;
    assign w_start_hi = w_radial ? ONE_Q32 : coef_word(r_coeff[w_top_idx]);

    assign w_adv      = !r_skid_valid;
    assign o_in_ready = w_adv;
    assign w_last     = r_vld[PIPE_LAT-1];

    // front end: squares, then radius
    assign w_xx = i_x_coord * i_x_coord;
    assign w_yy = i_y_coord * i_y_coord;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xx  <= w_xx[RAD_W-2:0];
            r_yy  <= w_yy[RAD_W-2:0];
            r_rad <= {1'b0, r_xx} + {1'b0, r_yy};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in_valid};
        end
    end

    assign w_rad[0] = r_rad;

    for (genvar s = 1; s < NUM_LANES; s++) begin : g_rad
        zae_delay #(.WIDTH(RAD_W), .DEPTH(CELL_LAT)) u_rad_dly (
            .i_clk (i_clk),
            .i_adv (w_adv),
            .i_d   (w_rad[s-1]),
            .o_q   (w_rad[s])
        );
    end

    assign w_acc[NUM_LANES] = w_radial ? coef_word(r_coeff[0]) : w_lane[NUM_LANES][NUM_LANES];

    for (genvar s = 1; s <= NUM_STATIONS; s++) begin : g_st
        for (genvar k = 1; k <= NUM_LANES; k++) begin : g_ln
            if (s <= NUM_LANES && s >= MAX_TERMS - k) begin : g_horner
                localparam int STEP = s - (MAX_TERMS - k);
                t_word w_a;
                t_word w_d;
                logic  w_act;

                if (s == MAX_TERMS - k) begin : g_first
                    if (k == NUM_LANES) begin : g_hi
                        assign w_a = w_start_hi;
                    end else begin : g_lo
                        assign w_a = ONE_Q32;
                    end
                end else begin : g_next
                    assign w_a = w_lane[s-1][k];
                end

                if (k == NUM_LANES) begin : g_shared
                    assign w_d   = w_radial ? POLY_CONST[POLY_START[k] + STEP]
                                            : coef_word(r_coeff[MAX_TERMS-1-s]);
                    assign w_act = w_radial ? (w_n > t_count'(k))
                                            : (w_n > t_count'(MAX_TERMS - s));
                end else begin : g_radial
                    assign w_d   = POLY_CONST[POLY_START[k] + STEP];
                    assign w_act = w_radial & (w_n > t_count'(k));
                end

                zae_cell #(.SHIFT(RAD_SHIFT)) u_cell (
                    .i_clk  (i_clk),
                    .i_adv  (w_adv),
                    .i_act  (w_act),
                    .i_a    (w_a),
                    .i_b    (t_opb'({1'b0, w_rad[s-1]})),
                    .i_d    (w_d),
                    .i_pass (w_a),
                    .o_y    (w_lane[s][k]),
                    .o_sat  (w_csat[s][k])
                );
            end else if (s == NUM_LANES + k) begin : g_mac
                zae_cell #(.SHIFT(COEF_SHIFT)) u_cell (
                    .i_clk  (i_clk),
                    .i_adv  (w_adv),
                    .i_act  (w_radial & (w_n > t_count'(k))),
                    .i_a    (w_lane[s-1][k]),
                    .i_b    (coef_opb(r_coeff[k])),
                    .i_d    (w_acc[s-1]),
                    .i_pass (w_acc[s-1]),
                    .o_y    (w_acc[s]),
                    .o_sat  (w_csat[s][k])
                );
                assign w_lane[s][k] = '0;
            end else if (s > NUM_LANES && s < NUM_LANES + k) begin : g_carry
                zae_delay #(.WIDTH(WORD_W), .DEPTH(CELL_LAT)) u_lane_dly (
                    .i_clk (i_clk),
                    .i_adv (w_adv),
                    .i_d   (w_lane[s-1][k]),
                    .o_q   (w_lane[s][k])
                );
                assign w_csat[s][k] = 1'b0;
            end else begin : g_idle
                assign w_lane[s][k] = '0;
                assign w_csat[s][k] = 1'b0;
            end
        end

        if (s == 1) begin : g_sat_head
            assign w_sat_d[s] = 1'b0;
        end else begin : g_sat_dly
            zae_delay #(.WIDTH(1), .DEPTH(CELL_LAT)) u_sat_dly (
                .i_clk (i_clk),
                .i_adv (w_adv),
                .i_d   (w_sat[s-1]),
                .o_q   (w_sat_d[s])
            );
        end
    end

    always_comb begin
        for (int s = 1; s <= NUM_STATIONS; s++) begin
            w_sat[s] = w_sat_d[s];
            for (int k = 1; k <= NUM_LANES; k++) begin
                w_sat[s] = w_sat[s] | w_csat[s][k];
            end
        end
    end

    assign w_result     = (w_n == '0) ? '0 : w_acc[NUM_STATIONS];
    assign w_result_sat = (w_n != '0) & w_sat[NUM_STATIONS];

    // output register and skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_skid_valid) begin
            if (w_last) begin
                if (!r_out_valid || i_out_ready) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end else if (i_out_ready) begin
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            if (w_last) begin
                if (!r_out_valid || i_out_ready) begin
                    r_out_value <= w_result;
                    r_out_sat   <= w_result_sat;
                end else begin
                    r_skid_value <= w_result;
                    r_skid_sat   <= w_result_sat;
                end
            end
        end else if (i_out_ready) begin
            r_out_value <= r_skid_value;
            r_out_sat   <= r_skid_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_wave_value = r_out_value;
    assign o_saturated  = r_out_sat;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a beat while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_out_ready))
        else $error("skid stage filled without a stalled output beat");

    a_freeze_on_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |=> $stable(r_vld))
        else $error("pipeline advanced while the skid stage was full");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted input beat did not enter the pipeline");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the zonal aberration evaluator: paced point stream, shadow predictor, scoreboard.
module tb_top;
    import zae_pkg::*;

    localparam int RUN_LIMIT   = 400000;
    localparam int PHASE_ITEMS = 62;
    localparam int RAND_PHASES = 24;

    localparam t_coord COORD_MAX = 18'sd131071;
    localparam t_coord COORD_MIN = -18'sd131072;
    localparam t_coef  COEF_MAX  = 32'sh7FFF_FFFF;
    localparam t_coef  COEF_MIN  = 32'sh8000_0000;
    localparam t_coef  COEF_ONE  = 32'sd1048576;

    typedef enum logic [1:0] {PACE_FULL, PACE_SRC_SLOW, PACE_SINK_SLOW, PACE_BOTH} t_pace;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef struct packed {
        t_word wave;
        logic  clip;
    } t_wave_res;

    logic           i_clk     = 1'b0;
    logic           i_rst_n   = 1'b0;
    logic           cfg_wen   = 1'b0;
    t_cfg_idx       cfg_index = '0;
    logic [31:0]    cfg_data  = '0;
    logic           in_valid  = 1'b0;
    logic           o_in_ready;
    t_coord         x_drv     = '0;
    t_coord         y_drv     = '0;
    logic           o_out_valid;
    logic           out_ready = 1'b0;
    t_word          o_wave_value;
    logic           o_saturated;

    logic           cfg_basis;
    t_count         cfg_terms;
    t_coef          cfg_coef [MAX_TERMS];
    t_coef          coef_plan [MAX_TERMS];
    logic           clip_seen;
    t_pace          pace = PACE_FULL;

    t_point         point_backlog [$];
    t_wave_res      wave_due [$];
    t_point         next_pt;
    t_wave_res      due;

    int             cycles    = 0;
    int             n_points  = 0;
    int             n_results = 0;
    int             n_clipped = 0;
    int             n_errors  = 0;
    int             n_settings = 0;

    zonal_aberration_evaluator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (cfg_wen),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_x_coord    (x_drv),
        .i_y_coord    (y_drv),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_wave_value (o_wave_value),
        .o_saturated  (o_saturated)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic signed [63:0] radial_coef(input int idx);
        case (idx)
            0:       return -64'sd2147483648;
            1:       return -64'sd4294967296;
            2:       return 64'sd715827884;
            3:       return -64'sd6442450944;
            4:       return 64'sd2576980378;
            5:       return -64'sd214748365;
            6:       return -64'sd8589934592;
            7:       return 64'sd5522082402;
            8:       return -64'sd1227132286;
            9:       return 64'sd61332133;
            10:      return -64'sd10737418240;
            11:      return 64'sd9544370814;
            12:      return -64'sd3579139270;
            13:      return 64'sd511315857;
            default: return -64'sd17042430;
        endcase
    endfunction

    function automatic t_word clamp_word(input logic signed [127:0] v);
        logic signed [127:0] hi, lo;
        hi = WORD_MAX;
        lo = WORD_MIN;
        if (v > hi) begin
            clip_seen = 1'b1;
            return WORD_MAX;
        end
        if (v < lo) begin
            clip_seen = 1'b1;
            return WORD_MIN;
        end
        return v[WORD_W-1:0];
    endfunction

    function automatic t_word scale_mul(input logic signed [63:0] a, input logic signed [63:0] b,
                                        input int shift);
        logic signed [127:0] wa, wb, prod;
        wa = a;
        wb = b;
        prod = (wa * wb) >>> shift;
        return clamp_word(prod);
    endfunction

    function automatic t_word sum_word(input logic signed [63:0] a, input logic signed [63:0] b);
        logic signed [127:0] wa, wb;
        wa = a;
        wb = b;
        return clamp_word(wa + wb);
    endfunction

    function automatic logic signed [63:0] coef_aligned(input int i);
        logic signed [63:0] v;
        v = cfg_coef[i];
        return v <<< COEF_ALIGN;
    endfunction

    function automatic t_wave_res eval_point(input t_point pt);
        logic signed [63:0] xs, ys, r, acc, p, c;
        int n, i, k;
        t_wave_res res;
        xs = pt.x;
        ys = pt.y;
        r = xs * xs + ys * ys;
        clip_seen = 1'b0;
        acc = 0;
        n = (cfg_terms > MAX_TERMS) ? MAX_TERMS : cfg_terms;
        if (n > 0) begin
            if (cfg_basis == BASIS_POWER) begin
                for (i = n - 1; i >= 0; i--) begin
                    p = scale_mul(acc, r, RAD_SHIFT);
                    acc = sum_word(p, coef_aligned(i));
                end
            end else begin
                acc = coef_aligned(0);
                for (k = 1; k < n; k++) begin
                    p = ONE_Q32;
                    for (i = 0; i < k; i++) begin
                        p = scale_mul(p, r, RAD_SHIFT);
                        p = sum_word(p, radial_coef(k * (k - 1) / 2 + i));
                    end
                    c = cfg_coef[k];
                    p = scale_mul(c, p, COEF_SHIFT);
                    acc = sum_word(acc, p);
                end
            end
        end
        res.wave = acc[WORD_W-1:0];
        res.clip = clip_seen;
        return res;
    endfunction

    function automatic logic idle_roll(input logic sender);
        int pct;
        pct = 0;
        if (pace == PACE_BOTH)
            pct = 19;
        else if ((sender && pace == PACE_SRC_SLOW) || (!sender && pace == PACE_SINK_SLOW))
            pct = 82;
        return $urandom_range(0, 99) < pct;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("%0t: run limit reached", $time);
            $display("zonal_aberration_evaluator: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                wave_due.push_back(eval_point(t_point'({x_drv, y_drv})));
                n_points++;
            end
            if (!in_valid || o_in_ready) begin
                if (point_backlog.size() != 0 && !idle_roll(1'b1)) begin
                    next_pt = point_backlog.pop_front();
                    in_valid <= 1'b1;
                    x_drv <= next_pt.x;
                    y_drv <= next_pt.y;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (wave_due.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual wave_value=%0d saturated=%0b",
                             $time, o_wave_value, o_saturated);
                    n_errors++;
                end else begin
                    due = wave_due.pop_front();
                    n_results++;
                    if (due.clip)
                        n_clipped++;
                    if (o_wave_value !== due.wave) begin
                        $display("%0t: wave_value expected %0d actual %0d",
                                 $time, due.wave, o_wave_value);
                        n_errors++;
                    end
                    if (o_saturated !== due.clip) begin
                        $display("%0t: saturated expected %0b actual %0b",
                                 $time, due.clip, o_saturated);
                        n_errors++;
                    end
                end
            end
            out_ready <= !idle_roll(1'b0);
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_BASIS_MODE: cfg_basis = data[0];
            REG_TERM_COUNT: cfg_terms = data[COUNT_W-1:0];
            default:        cfg_coef[idx - REG_COEFF_0] = data;
        endcase
    endtask

    task automatic apply_config(input logic basis, input t_count count);
        logic [31:0] noise;
        noise = $urandom;
        write_reg(REG_BASIS_MODE, {noise[31:1], basis});
        write_reg(REG_TERM_COUNT, {noise[28:0], count});
        for (int i = 0; i < MAX_TERMS; i++)
            write_reg(t_cfg_idx'(REG_COEFF_0 + i), coef_plan[i]);
        @(posedge i_clk);
        cfg_wen <= 1'b0;
        n_settings++;
        @(negedge i_clk);
    endtask

    task automatic push_xy(input t_coord x, input t_coord y);
        point_backlog.push_back(t_point'({x, y}));
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (point_backlog.size() != 0 || in_valid || wave_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_coef rand_coef();
        int v;
        case ($urandom_range(0, 5))
            0, 1: begin
                v = $urandom_range(0, 4194304) - 2097152;
                return t_coef'(v);
            end
            2: begin
                v = $urandom_range(0, 134217728) - 67108864;
                return t_coef'(v);
            end
            3:       return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
            4:       return '0;
            default: return t_coef'($urandom);
        endcase
    endfunction

    function automatic t_coord rand_coord(input int sel);
        int v;
        logic [31:0] raw;
        if (sel < 7) begin
            v = $urandom_range(0, 131072) - 65536;
            return v[COORD_W-1:0];
        end
        if (sel < 9) begin
            raw = $urandom;
            return raw[COORD_W-1:0];
        end
        case ($urandom_range(0, 3))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            default: return -18'sd1;
        endcase
    endfunction

    initial begin
        int sel;
        t_count count;
        cfg_basis = 1'b0;
        cfg_terms = '0;
        for (int i = 0; i < MAX_TERMS; i++)
            cfg_coef[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // registers at reset: count zero in power mode
        push_xy('0, '0);
        push_xy(COORD_MAX, COORD_MAX);
        drain();

        for (int i = 0; i < MAX_TERMS; i++)
            coef_plan[i] = COEF_MAX;
        apply_config(BASIS_POWER, 3'd7);
        push_xy('0, '0);
        push_xy(18'sd65536, '0);
        push_xy(COORD_MAX, COORD_MAX);
        push_xy(COORD_MIN, COORD_MIN);
        push_xy(COORD_MIN, COORD_MAX);
        drain();

        for (int i = 0; i < MAX_TERMS; i++)
            coef_plan[i] = (i % 2) ? COEF_MAX : COEF_MIN;
        apply_config(BASIS_RADIAL, 3'd6);
        push_xy('0, '0);
        push_xy(18'sd65536, '0);
        push_xy(COORD_MIN, COORD_MIN);
        push_xy(-18'sd1, 18'sd1);
        push_xy(18'sd46341, -18'sd46341);
        drain();

        for (int i = 0; i < MAX_TERMS; i++)
            coef_plan[i] = (i % 2) ? COEF_ONE : -COEF_ONE;
        apply_config(BASIS_POWER, 3'd6);
        push_xy(18'sd32768, '0);
        push_xy('0, -18'sd65536);
        push_xy(COORD_MAX, COORD_MIN);
        drain();

        for (int i = 0; i < MAX_TERMS; i++)
            coef_plan[i] = COEF_ONE;
        apply_config(BASIS_RADIAL, 3'd3);
        push_xy('0, '0);
        push_xy(18'sd65536, '0);
        push_xy(18'sd92682, '0);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            pace = t_pace'(ph % 4);
            for (int i = 0; i < MAX_TERMS; i++)
                coef_plan[i] = rand_coef();
            sel = $urandom_range(0, 9);
            if (sel == 0)
                count = '0;
            else if (sel == 1)
                count = 3'd7;
            else
                count = t_count'($urandom_range(1, MAX_TERMS));
            apply_config(1'($urandom_range(0, 1)), count);
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                sel = $urandom_range(0, 9);
                push_xy(rand_coord(sel), rand_coord(sel));
            end
            drain();
        end

        repeat (PIPE_LAT + 16) @(posedge i_clk);
        if (wave_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, wave_due.size());
            n_errors++;
        end
        $display("covered %0d points over %0d register settings in both bases, four pacing modes",
                 n_points, n_settings);
        $display("checked %0d results, %0d of them clipped, %0d errors",
                 n_results, n_clipped, n_errors);
        if (n_errors == 0) begin
            $display("zonal_aberration_evaluator: match");
        end else begin
            $display("zonal_aberration_evaluator: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/zae_pkg.sv
sv/zae_delay.sv
sv/zae_cell.sv
sv/zonal_aberration_evaluator.sv
tb/sv/tb_top.sv
